// ===== design/fip_pkg.sv =====
// Shared types and constants for the integer power block.
`timescale 1ns / 1ps
package fip_pkg;

  localparam logic [63:0] FP_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_QNAN_DEF = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QUIET    = 64'h0008_0000_0000_0000;
  localparam logic [10:0] FP_EXP_MAX  = 11'h7FF;

  localparam logic [1:0] METH_POS = 2'd0;
  localparam logic [1:0] METH_REP = 2'd1;
  localparam logic [1:0] METH_SQM = 2'd2;

  typedef logic signed [13:0] fexp_t;

  localparam fexp_t MUL_BIAS     = 14'sd1022;
  localparam fexp_t RCP_BIAS     = 14'sd2046;
  localparam fexp_t DENORM_FLOOR = -14'sd110;
  localparam fexp_t EXP_INF      = 14'sd2047;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_RNORM,
    F_DIV,
    F_NORM,
    F_DENORM,
    F_ROUND
  } fpu_state_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DISPATCH,
    C_REP_TEST,
    C_REP_Y_WAIT,
    C_REP_Z_WAIT,
    C_SQ_TEST,
    C_SQ_SQ_WAIT,
    C_SQ_MUL_WAIT,
    C_FIN,
    C_RCP_WAIT,
    C_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    FS_ACC_BASE,
    FS_FPU_BASE,
    FS_AUX_AUX,
    FS_ACC_FPU,
    FS_RCP_ACC
  } fsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_FPU,
    ACC_AUX
  } acc_op_t;

  typedef enum logic [1:0] {
    N_HOLD,
    N_DEC2,
    N_SHR
  } n_op_t;

  typedef struct packed {
    logic    accept;
    logic    fpu_start;
    fsel_t   fpu_sel;
    acc_op_t acc_op;
    logic    aux_load;
    n_op_t   n_op;
    logic    ops_load;
    logic    ops_inc;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic fpu_done;
    logic eq_acc;
    logic n_zero;
    logic n_one;
    logic n_odd;
    logic n_bit1;
    logic neg;
    logic meth_pos;
    logic meth_rep;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/fip_fpu.sv =====
// Iterative binary64 multiply and reciprocal unit, round to nearest even.
`timescale 1ns / 1ps
module fip_fpu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        op_rcp,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] res
);
  import fip_pkg::*;

  fpu_state_t  st_r, st_nxt;
  logic        done_r;
  logic [63:0] res_r;
  logic        sign_r;
  fexp_t       e_r;
  logic [105:0] p_r;
  logic        sticky_r;
  logic [52:0] ma_r, mb_r;
  logic [53:0] rem_r;
  logic [5:0]  cnt_r;
  logic [53:0] pp_r;

  logic        a_sign, b_sign;
  logic [10:0] a_exp, b_exp, a_eff, b_eff;
  logic [51:0] a_frac, b_frac;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        special;
  logic [63:0] spec_val;
  fexp_t       e_mul;

  logic [26:0]  mx, my;
  logic [53:0]  pp_prod;
  logic [105:0] pp_term;

  logic [53:0] rem_sub, rem_new;
  logic        q_bit;
  logic [55:0] q_next;

  logic        rnd_inc;
  logic [53:0] m54;
  logic [52:0] mant;
  fexp_t       e_fin;
  logic [10:0] exp_field;
  logic [63:0] rnd_val;

  assign a_sign = opa[63];
  assign a_exp  = opa[62:52];
  assign a_frac = opa[51:0];
  assign b_sign = opb[63];
  assign b_exp  = opb[62:52];
  assign b_frac = opb[51:0];
  assign a_nan  = (a_exp == FP_EXP_MAX) && (a_frac != '0);
  assign b_nan  = (b_exp == FP_EXP_MAX) && (b_frac != '0);
  assign a_inf  = (a_exp == FP_EXP_MAX) && (a_frac == '0);
  assign b_inf  = (b_exp == FP_EXP_MAX) && (b_frac == '0);
  assign a_zero = (a_exp == '0) && (a_frac == '0);
  assign b_zero = (b_exp == '0) && (b_frac == '0);
  assign a_eff  = (a_exp == '0) ? 11'd1 : a_exp;
  assign b_eff  = (b_exp == '0) ? 11'd1 : b_exp;
  assign e_mul  = fexp_t'({3'b000, a_eff}) + fexp_t'({3'b000, b_eff}) - MUL_BIAS;

  always_comb begin
    special  = 1'b0;
    spec_val = '0;
    if (op_rcp) begin
      special = a_nan || a_inf || a_zero;
      if (a_nan) begin
        spec_val = opa | FP_QUIET;
      end else if (a_inf) begin
        spec_val = {a_sign, 63'd0};
      end else begin
        spec_val = {a_sign, FP_EXP_MAX, 52'd0};
      end
    end else begin
      special = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
      if (a_nan) begin
        spec_val = opa | FP_QUIET;
      end else if (b_nan) begin
        spec_val = opb | FP_QUIET;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        spec_val = FP_QNAN_DEF;
      end else if (a_inf || b_inf) begin
        spec_val = {a_sign ^ b_sign, FP_EXP_MAX, 52'd0};
      end else begin
        spec_val = {a_sign ^ b_sign, 63'd0};
      end
    end
  end

  // 27x27 partial products: lo*lo, lo*hi, hi*lo, hi*hi
  assign mx      = cnt_r[1] ? {1'b0, ma_r[52:27]} : ma_r[26:0];
  assign my      = cnt_r[0] ? {1'b0, mb_r[52:27]} : mb_r[26:0];
  assign pp_prod = mx * my;

  always_comb begin
    unique case (cnt_r[2:0])
      3'd1:       pp_term = {52'd0, pp_r};
      3'd2, 3'd3: pp_term = {52'd0, pp_r} << 27;
      default:    pp_term = {52'd0, pp_r} << 54;
    endcase
  end

  assign q_bit   = rem_r >= {1'b0, ma_r};
  assign rem_sub = rem_r - {1'b0, ma_r};
  assign rem_new = q_bit ? rem_sub : rem_r;
  assign q_next  = {p_r[54:0], q_bit};

  assign rnd_inc   = p_r[52] && (sticky_r || (p_r[51:0] != '0) || p_r[53]);
  assign m54       = {1'b0, p_r[105:53]} + {53'd0, rnd_inc};
  assign mant      = m54[53] ? m54[53:1] : m54[52:0];
  assign e_fin     = e_r + (m54[53] ? 14'sd1 : 14'sd0);
  assign exp_field = mant[52] ? e_fin[10:0] : 11'd0;
  assign rnd_val   = (e_fin >= EXP_INF) ? {sign_r, FP_EXP_MAX, 52'd0}
                                        : {sign_r, exp_field, mant[51:0]};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: begin
        if (start && !special) st_nxt = op_rcp ? F_RNORM : F_MUL;
      end
      F_MUL: begin
        if (cnt_r[2:0] == 3'd4) st_nxt = F_NORM;
      end
      F_RNORM: begin
        if (ma_r[52]) st_nxt = F_DIV;
      end
      F_DIV: begin
        if (cnt_r == 6'd55) st_nxt = F_NORM;
      end
      F_NORM: begin
        if (p_r[105] || (e_r <= 14'sd1)) st_nxt = (e_r < 14'sd1) ? F_DENORM : F_ROUND;
      end
      F_DENORM: begin
        if (e_r >= 14'sd1) st_nxt = F_ROUND;
      end
      F_ROUND: st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= ((st_r == F_IDLE) && start && special) || (st_r == F_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      F_IDLE: begin
        if (start) begin
          if (special) begin
            res_r <= spec_val;
          end
          ma_r     <= {a_exp != '0, a_frac};
          mb_r     <= {b_exp != '0, b_frac};
          sign_r   <= op_rcp ? a_sign : (a_sign ^ b_sign);
          e_r      <= op_rcp ? fexp_t'({3'b000, a_eff}) : e_mul;
          p_r      <= '0;
          sticky_r <= 1'b0;
          cnt_r    <= '0;
        end
      end
      F_MUL: begin
        if (cnt_r[2:0] != 3'd4) pp_r <= pp_prod;
        if (cnt_r[2:0] != 3'd0) p_r <= p_r + pp_term;
        cnt_r <= cnt_r + 6'd1;
      end
      F_RNORM: begin
        if (ma_r[52]) begin
          e_r   <= RCP_BIAS - e_r;
          rem_r <= 54'd1 << 52;
          cnt_r <= '0;
        end else begin
          ma_r <= ma_r << 1;
          e_r  <= e_r - 14'sd1;
        end
      end
      F_DIV: begin
        rem_r <= {rem_new[52:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd55) begin
          p_r      <= {q_next, 50'd0};
          sticky_r <= rem_new != '0;
        end else begin
          p_r <= {50'd0, q_next};
        end
      end
      F_NORM: begin
        if (!(p_r[105] || (e_r <= 14'sd1))) begin
          p_r <= p_r << 1;
          e_r <= e_r - 14'sd1;
        end
      end
      F_DENORM: begin
        if (e_r < DENORM_FLOOR) begin
          sticky_r <= sticky_r || (p_r != '0);
          p_r      <= '0;
          e_r      <= 14'sd1;
        end else if (e_r < 14'sd1) begin
          sticky_r <= sticky_r || p_r[0];
          p_r      <= p_r >> 1;
          e_r      <= e_r + 14'sd1;
        end
      end
      F_ROUND: res_r <= rnd_val;
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/fip_datapath.sv =====
// Datapath: operand registers, exponent counter, op counters, output beat register.
`timescale 1ns / 1ps
module fip_datapath #(
  parameter int EXP_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fip_pkg::dp_cmd_t            cmd,
  output fip_pkg::dp_stat_t           stat,
  input  logic [63:0]                 in_base_bits,
  input  logic signed [EXP_WIDTH-1:0] in_exponent,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_result_bits,
  output logic [31:0]                 out_op_count,
  output logic [63:0]                 out_op_total
);
  import fip_pkg::*;

  logic [1:0]           method_r;
  logic [63:0]          base_r, acc_r, aux_r;
  logic [EXP_WIDTH-1:0] n_r;
  logic                 neg_r;
  logic [63:0]          ops_r, total_r;
  logic                 out_valid_r;
  logic [63:0]          out_result_r, out_total_r;
  logic [31:0]          out_count_r;

  logic [EXP_WIDTH-1:0] raw, mag;
  logic                 in_neg;
  logic [63:0]          total_nxt;
  logic [63:0]          fpu_a, fpu_b, fpu_res;
  logic                 fpu_done;

  assign raw       = in_exponent;
  assign in_neg    = raw[EXP_WIDTH-1];
  assign mag       = in_neg ? (~raw + EXP_WIDTH'(1)) : raw;
  assign total_nxt = total_r + ops_r;

  always_comb begin
    fpu_a = acc_r;
    fpu_b = base_r;
    unique case (cmd.fpu_sel)
      FS_ACC_BASE: begin fpu_a = acc_r;   fpu_b = base_r;  end
      FS_FPU_BASE: begin fpu_a = fpu_res; fpu_b = base_r;  end
      FS_AUX_AUX:  begin fpu_a = aux_r;   fpu_b = aux_r;   end
      FS_ACC_FPU:  begin fpu_a = acc_r;   fpu_b = fpu_res; end
      FS_RCP_ACC:  begin fpu_a = acc_r;   fpu_b = acc_r;   end
      default:     begin fpu_a = acc_r;   fpu_b = base_r;  end
    endcase
  end

  fip_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.fpu_start),
    .op_rcp (cmd.fpu_sel == FS_RCP_ACC),
    .opa    (fpu_a),
    .opb    (fpu_b),
    .done   (fpu_done),
    .res    (fpu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r    <= METH_SQM;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) method_r <= cfg_wr_data;
      if (cmd.out_load) begin
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r <= in_base_bits;
      aux_r  <= in_base_bits;
      acc_r  <= (!method_r[1] || !mag[0]) ? FP_ONE : in_base_bits;
      n_r    <= mag;
      neg_r  <= in_neg;
      ops_r  <= '0;
    end else begin
      unique case (cmd.acc_op)
        ACC_FPU: acc_r <= fpu_res;
        ACC_AUX: acc_r <= aux_r;
        default: ;
      endcase
      if (cmd.aux_load) aux_r <= fpu_res;
      unique case (cmd.n_op)
        N_DEC2:  n_r <= n_r - EXP_WIDTH'(2);
        N_SHR:   n_r <= n_r >> 1;
        default: ;
      endcase
      if (cmd.ops_load) begin
        ops_r <= 64'(n_r);
      end else if (cmd.ops_inc) begin
        ops_r <= ops_r + 64'd1;
      end
    end
    if (cmd.out_load) begin
      out_result_r <= acc_r;
      out_count_r  <= ops_r[31:0];
      out_total_r  <= total_nxt;
    end
  end

  assign stat.fpu_done = fpu_done;
  assign stat.eq_acc   = fpu_res == acc_r;
  assign stat.n_zero   = n_r == '0;
  assign stat.n_one    = n_r == EXP_WIDTH'(1);
  assign stat.n_odd    = n_r[0];
  assign stat.n_bit1   = n_r[1];
  assign stat.neg      = neg_r;
  assign stat.meth_pos = method_r == METH_POS;
  assign stat.meth_rep = (method_r == METH_POS) || (method_r == METH_REP);
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_r;
  assign out_op_count    = out_count_r;
  assign out_op_total    = out_total_r;

endmodule

// ===== design/fip_ctrl.sv =====
// Controller state machine sequencing the power algorithms.
`timescale 1ns / 1ps
module fip_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fip_pkg::dp_stat_t  stat,
  output fip_pkg::dp_cmd_t   cmd
);
  import fip_pkg::*;

  ctl_state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      C_IDLE:     if (in_valid) st_nxt = C_DISPATCH;
      C_DISPATCH: begin
        if (stat.meth_pos && stat.neg) begin
          st_nxt = C_OUT;
        end else begin
          st_nxt = stat.meth_rep ? C_REP_TEST : C_SQ_TEST;
        end
      end
      C_REP_TEST: st_nxt = stat.n_zero ? C_FIN : C_REP_Y_WAIT;
      C_REP_Y_WAIT: begin
        if (stat.fpu_done) st_nxt = (stat.n_one || stat.eq_acc) ? C_FIN : C_REP_Z_WAIT;
      end
      C_REP_Z_WAIT: begin
        if (stat.fpu_done) st_nxt = stat.eq_acc ? C_FIN : C_REP_TEST;
      end
      C_SQ_TEST:  st_nxt = stat.n_zero ? C_FIN : C_SQ_SQ_WAIT;
      C_SQ_SQ_WAIT: begin
        if (stat.fpu_done) st_nxt = stat.n_bit1 ? C_SQ_MUL_WAIT : C_SQ_TEST;
      end
      C_SQ_MUL_WAIT: if (stat.fpu_done) st_nxt = C_SQ_TEST;
      C_FIN:      st_nxt = stat.neg ? C_RCP_WAIT : C_OUT;
      C_RCP_WAIT: if (stat.fpu_done) st_nxt = C_OUT;
      C_OUT:      if (!stat.out_busy) st_nxt = C_IDLE;
      default:    st_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.fpu_sel  = FS_ACC_BASE;
    cmd.acc_op   = ACC_HOLD;
    cmd.n_op     = N_HOLD;
    in_ready     = 1'b0;
    unique case (st_r)
      C_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      C_DISPATCH: cmd.ops_load = stat.meth_rep && !(stat.meth_pos && stat.neg);
      C_REP_TEST: begin
        cmd.fpu_start = !stat.n_zero;
        cmd.fpu_sel   = FS_ACC_BASE;
      end
      C_REP_Y_WAIT: begin
        if (stat.fpu_done) begin
          cmd.aux_load = 1'b1;
          if (stat.n_one) begin
            cmd.acc_op = ACC_FPU;
          end else if (!stat.eq_acc) begin
            cmd.fpu_start = 1'b1;
            cmd.fpu_sel   = FS_FPU_BASE;
          end
        end
      end
      C_REP_Z_WAIT: begin
        if (stat.fpu_done) begin
          cmd.n_op = N_DEC2;
          if (stat.eq_acc) begin
            cmd.acc_op = stat.n_odd ? ACC_AUX : ACC_HOLD;
          end else begin
            cmd.acc_op = ACC_FPU;
          end
        end
      end
      C_SQ_TEST: begin
        cmd.fpu_start = !stat.n_zero;
        cmd.fpu_sel   = FS_AUX_AUX;
      end
      C_SQ_SQ_WAIT: begin
        if (stat.fpu_done) begin
          cmd.aux_load  = 1'b1;
          cmd.ops_inc   = 1'b1;
          cmd.n_op      = N_SHR;
          cmd.fpu_start = stat.n_bit1;
          cmd.fpu_sel   = FS_ACC_FPU;
        end
      end
      C_SQ_MUL_WAIT: begin
        if (stat.fpu_done) begin
          cmd.acc_op  = ACC_FPU;
          cmd.ops_inc = 1'b1;
        end
      end
      C_FIN: begin
        cmd.fpu_start = stat.neg;
        cmd.fpu_sel   = FS_RCP_ACC;
      end
      C_RCP_WAIT: begin
        cmd.fpu_sel = FS_RCP_ACC;
        if (stat.fpu_done) begin
          cmd.acc_op  = ACC_FPU;
          cmd.ops_inc = 1'b1;
        end
      end
      C_OUT:   cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== design/float_integer_power.sv =====
// Top level: binary64 base raised to a signed integer exponent.
// One item at a time; a zero exponent needs no multiply.
// A multiply forms partial products, normalises, denormalises and rounds (a special
// operand skips this); the reciprocal normalises and divides, slowest on subnormal inputs.
// Square and multiply: up to 2*EXP_WIDTH multiplies, plus a reciprocal if negative;
// repeated multiplication: up to |exponent| multiplies. Reset clears method (to 2), total.
`timescale 1ns / 1ps
module float_integer_power #(
  parameter int EXP_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 in_base_bits,
  input  logic signed [EXP_WIDTH-1:0] in_exponent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_result_bits,
  output logic [31:0]                 out_op_count,
  output logic [63:0]                 out_op_total,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_wr_data
);
  import fip_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fip_datapath #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_base_bits    (in_base_bits),
    .in_exponent     (in_exponent),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_bits (out_result_bits),
    .out_op_count    (out_op_count),
    .out_op_total    (out_op_total)
  );

endmodule
